/* rtl/pdt_pkg.sv */
// ----------------------------------------------------------------------------
// pdt_pkg
// Shared types, codes and digit helpers for the packed date/time text block.
// ----------------------------------------------------------------------------
package pdt_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_IDX_HOUR_MODE  = 2'd0;
    localparam logic [1:0] CFG_IDX_DATE_ORDER = 2'd1;

    // hour_mode codes
    localparam logic HOUR_MODE_12 = 1'b0;
    localparam logic HOUR_MODE_24 = 1'b1;

    // date_order codes
    localparam logic [1:0] DATE_ORDER_MDY = 2'd0;
    localparam logic [1:0] DATE_ORDER_YMD = 2'd1;
    localparam logic [1:0] DATE_ORDER_DMY = 2'd2;

    // ascii codes
    localparam logic [6:0] ASCII_ZERO  = 7'h30;
    localparam logic [6:0] ASCII_SPACE = 7'h20;
    localparam logic [6:0] ASCII_A     = 7'h41;
    localparam logic [6:0] ASCII_P     = 7'h50;

    // year offset and wrap
    localparam logic [7:0] YEAR_BASE = 8'd80;
    localparam logic [7:0] YEAR_WRAP = 8'd100;

    // hour fold point for twelve-hour form
    localparam logic [4:0] HOUR_NOON = 5'd12;

    // multiply-shift reciprocal of ten, exact for values below 100
    localparam logic [6:0] RECIP_TEN = 7'd103;
    localparam int         RECIP_SHIFT = 10;

    // unpacked date
    typedef struct packed {
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
    } t_date;

    // one result word
    typedef struct packed {
        logic       date_changed;
        logic [6:0] date_char0;
        logic [6:0] date_char1;
        logic [6:0] date_char2;
        logic [6:0] date_char3;
        logic [6:0] date_char4;
        logic [6:0] date_char5;
        logic [6:0] time_char0;
        logic [6:0] time_char1;
        logic [6:0] time_char2;
        logic [6:0] time_char3;
        logic [6:0] time_char4;
    } t_result;

    // tens digit of a value below 100
    function automatic logic [3:0] dec_tens(input logic [6:0] v);
        logic [13:0] prod;
        prod = 14'(v) * 14'(RECIP_TEN);
        return 4'(prod >> RECIP_SHIFT);
    endfunction

    // units digit of a value below 100
    function automatic logic [3:0] dec_units(input logic [6:0] v);
        logic [3:0] t;
        logic [6:0] tx10;
        t    = dec_tens(v);
        tx10 = {t, 3'b000} - 7'({t, 1'b0}) + 7'({t, 2'b00});
        return 4'(v - tx10);
    endfunction

endpackage

/* rtl/pdt_text.sv */
// ----------------------------------------------------------------------------
// pdt_text
// Converts a value below 100 into two ascii digits, with optional blanking
// of a zero tens digit.
// ----------------------------------------------------------------------------
module pdt_text
    import pdt_pkg::*;
(
    input  logic [6:0] i_value,
    input  logic       i_blank,
    output logic [6:0] o_tens_char,
    output logic [6:0] o_units_char
);

    logic [3:0] tens;
    logic [3:0] units;

    // decimal split
    assign tens  = dec_tens(i_value);
    assign units = dec_units(i_value);

    // ascii encode, space for a blanked zero tens digit
    assign o_tens_char  = (i_blank && tens == 4'd0) ? ASCII_SPACE
                                                    : ASCII_ZERO + 7'(tens);
    assign o_units_char = ASCII_ZERO + 7'(units);

endmodule

/* rtl/pdt_date_track.sv */
// ----------------------------------------------------------------------------
// pdt_date_track
// Holds the last date seen and flags a change against the incoming date.
// ----------------------------------------------------------------------------
module pdt_date_track
    import pdt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_load,
    input  t_date i_date,
    output logic  o_changed
);

    t_date r_prev;

    // compare against stored date
    assign o_changed = (r_prev != i_date);

    // store the date of every accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (i_load) begin
            r_prev <= i_date;
        end
    end

endmodule

/* rtl/pdt_fields.sv */
// ----------------------------------------------------------------------------
// pdt_fields
// Unpacks the time and date words, orders the date fields and folds the
// hour into twelve-hour form when selected.
// ----------------------------------------------------------------------------
module pdt_fields
    import pdt_pkg::*;
(
    input  logic [15:0] i_time_word,
    input  logic [15:0] i_date_word,
    input  logic        i_hour_mode,
    input  logic [1:0]  i_date_order,
    output t_date       o_date,
    output logic [6:0]  o_field0,
    output logic [6:0]  o_field1,
    output logic [6:0]  o_field2,
    output logic        o_blank0,
    output logic [6:0]  o_hour_show,
    output logic [6:0]  o_minute,
    output logic [6:0]  o_suffix
);

    logic [4:0] hour;
    logic [7:0] year_sum;
    logic [7:0] year_wrap;

    // field unpack
    assign hour     = i_time_word[15:11];
    assign o_minute = 7'(i_time_word[10:5]);
    assign o_date.day   = i_date_word[4:0];
    assign o_date.month = i_date_word[8:5];

    // year = (field + 80) mod 100, sum never reaches 300
    assign year_sum  = 8'(i_date_word[15:9]) + YEAR_BASE;
    assign year_wrap = (year_sum >= 8'(2 * YEAR_WRAP)) ? year_sum - 8'(2 * YEAR_WRAP)
                     : (year_sum >= YEAR_WRAP)          ? year_sum - YEAR_WRAP
                     : year_sum;
    assign o_date.year = year_wrap[6:0];

    // date field order
    always_comb begin
        case (i_date_order)
            DATE_ORDER_YMD: begin
                o_field0 = o_date.year;
                o_field1 = 7'(o_date.month);
                o_field2 = 7'(o_date.day);
                o_blank0 = 1'b0;
            end
            DATE_ORDER_DMY: begin
                o_field0 = 7'(o_date.day);
                o_field1 = 7'(o_date.month);
                o_field2 = o_date.year;
                o_blank0 = 1'b1;
            end
            default: begin
                o_field0 = 7'(o_date.month);
                o_field1 = 7'(o_date.day);
                o_field2 = o_date.year;
                o_blank0 = 1'b1;
            end
        endcase
    end

    // hour shown and meridian suffix
    always_comb begin
        if (i_hour_mode == HOUR_MODE_24) begin
            o_hour_show = 7'(hour);
            o_suffix    = 7'd0;
        end else begin
            if (hour == 5'd0) begin
                o_hour_show = 7'(HOUR_NOON);
            end else if (hour > HOUR_NOON) begin
                o_hour_show = 7'(hour - HOUR_NOON);
            end else begin
                o_hour_show = 7'(hour);
            end
            o_suffix = (hour < HOUR_NOON) ? ASCII_A : ASCII_P;
        end
    end

endmodule

/* rtl/packed_date_time_to_display_text.sv */
// ----------------------------------------------------------------------------
// packed_date_time_to_display_text
// Turns a packed time word and date word into display characters and flags
// a change of date against the last word seen.
//
//   channel   direction  handshake                  payload
//   in        sink       i_in_valid / o_in_ready    i_time_word, i_date_word
//   out       source     o_out_valid / i_out_ready  o_date_changed, o_*_char*
//   cfg       sink       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One word in per cycle while the skid register is empty; each result is
// registered in the result register, by way of the skid register when the
// output stalls. Unpack, decimal split and compare sit in one stage ahead
// of the result register. Input ready drops only while the skid register is
// full. Reset is synchronous; it clears both valid flags and the stored
// date to zero, which empties the output.
// ----------------------------------------------------------------------------
module packed_date_time_to_display_text
    import pdt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_time_word,
    input  logic [15:0] i_date_word,
    // result words
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_date_changed,
    output logic [6:0]  o_date_char0,
    output logic [6:0]  o_date_char1,
    output logic [6:0]  o_date_char2,
    output logic [6:0]  o_date_char3,
    output logic [6:0]  o_date_char4,
    output logic [6:0]  o_date_char5,
    output logic [6:0]  o_time_char0,
    output logic [6:0]  o_time_char1,
    output logic [6:0]  o_time_char2,
    output logic [6:0]  o_time_char3,
    output logic [6:0]  o_time_char4,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [1:0]  i_cfg_data
);

    logic       r_hour_mode;
    logic [1:0] r_date_order;

    logic       in_acc;
    t_date      cur_date;
    logic [6:0] field0;
    logic [6:0] field1;
    logic [6:0] field2;
    logic       blank0;
    logic [6:0] hour_show;
    logic [6:0] minute;
    logic [6:0] suffix;
    logic       changed;
    t_result    n_result;

    logic       r_out_valid;
    t_result    r_out;
    logic       r_skid_valid;
    t_result    r_skid;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hour_mode  <= HOUR_MODE_12;
            r_date_order <= DATE_ORDER_MDY;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_IDX_HOUR_MODE) begin
                r_hour_mode <= i_cfg_data[0];
            end else if (i_cfg_index == CFG_IDX_DATE_ORDER) begin
                r_date_order <= i_cfg_data;
            end
        end
    end

    // input handshake
    assign o_in_ready = !r_skid_valid;
    assign in_acc     = i_in_valid && o_in_ready;

    // field unpack and ordering
    pdt_fields u_fields (
        .i_time_word  (i_time_word),
        .i_date_word  (i_date_word),
        .i_hour_mode  (r_hour_mode),
        .i_date_order (r_date_order),
        .o_date       (cur_date),
        .o_field0     (field0),
        .o_field1     (field1),
        .o_field2     (field2),
        .o_blank0     (blank0),
        .o_hour_show  (hour_show),
        .o_minute     (minute),
        .o_suffix     (suffix)
    );

    // date change tracking
    pdt_date_track u_track (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (in_acc),
        .i_date    (cur_date),
        .o_changed (changed)
    );

    // character conversion
    pdt_text u_text_f0 (
        .i_value      (field0),
        .i_blank      (blank0),
        .o_tens_char  (n_result.date_char0),
        .o_units_char (n_result.date_char1)
    );

    pdt_text u_text_f1 (
        .i_value      (field1),
        .i_blank      (1'b0),
        .o_tens_char  (n_result.date_char2),
        .o_units_char (n_result.date_char3)
    );

    pdt_text u_text_f2 (
        .i_value      (field2),
        .i_blank      (1'b0),
        .o_tens_char  (n_result.date_char4),
        .o_units_char (n_result.date_char5)
    );

    pdt_text u_text_hour (
        .i_value      (hour_show),
        .i_blank      (1'b1),
        .o_tens_char  (n_result.time_char0),
        .o_units_char (n_result.time_char1)
    );

    pdt_text u_text_min (
        .i_value      (minute),
        .i_blank      (1'b0),
        .o_tens_char  (n_result.time_char2),
        .o_units_char (n_result.time_char3)
    );

    assign n_result.date_changed = changed;
    assign n_result.time_char4   = suffix;

    // result register and skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_acc;
            end
        end else if (in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_out_ready) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_acc) begin
                r_out <= n_result;
            end
        end else if (in_acc) begin
            r_skid <= n_result;
        end
    end

    // output ports
    assign o_out_valid    = r_out_valid;
    assign o_date_changed = r_out.date_changed;
    assign o_date_char0   = r_out.date_char0;
    assign o_date_char1   = r_out.date_char1;
    assign o_date_char2   = r_out.date_char2;
    assign o_date_char3   = r_out.date_char3;
    assign o_date_char4   = r_out.date_char4;
    assign o_date_char5   = r_out.date_char5;
    assign o_time_char0   = r_out.time_char0;
    assign o_time_char1   = r_out.time_char1;
    assign o_time_char2   = r_out.time_char2;
    assign o_time_char3   = r_out.time_char3;
    assign o_time_char4   = r_out.time_char4;

endmodule

/* sim/tb_packed_date_time_to_display_text.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_packed_date_time_to_display_text
// Drives packed time and date words into the block and compares every result
// word, field by field, with a behavioral model of the text conversion and
// the stored-date compare, or with the text given by a typed table row. A
// short table covers extremes, all date orders, both hour modes and the
// aliased years, then random traffic runs under three patterns of source
// and sink stalls with the settings changed between runs while the block is idle.
// ----------------------------------------------------------------------------
module tb_packed_date_time_to_display_text;
    import pdt_pkg::*;

    // codes the package leaves unnamed
    localparam logic [1:0] DATE_ORDER_SPARE = 2'd3;
    localparam logic [1:0] CFG_IDX_SPARE    = 2'd3;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_TICKS = 4;
    localparam int NUM_ROWS     = 19;
    localparam int RUN_WORDS    = 150;

    localparam t_result NO_TEXT = '0;

    // one row of the directed table
    typedef struct packed {
        logic        hm;
        logic [1:0]  ord;
        logic [15:0] tw;
        logic [15:0] dw;
        logic        typed;
        t_result     res;
    } t_row;

    localparam t_row DIRECTED [NUM_ROWS] = '{
        // zero time, year field 20 matches the all-zero stored date
        '{HOUR_MODE_12, DATE_ORDER_MDY, 16'h0000, 16'h2800, 1'b1,
          '{1'b0, ASCII_SPACE, ASCII_ZERO, ASCII_ZERO, ASCII_ZERO, ASCII_ZERO,
            ASCII_ZERO, ASCII_ZERO + 7'd1, ASCII_ZERO + 7'd2, ASCII_ZERO,
            ASCII_ZERO, ASCII_A}},
        // all ones: hour 31, minute 63, month 15, day 31, year 07
        '{HOUR_MODE_12, DATE_ORDER_MDY, 16'hFFFF, 16'hFFFF, 1'b1,
          '{1'b1, ASCII_ZERO + 7'd1, ASCII_ZERO + 7'd5, ASCII_ZERO + 7'd3,
            ASCII_ZERO + 7'd1, ASCII_ZERO, ASCII_ZERO + 7'd7, ASCII_ZERO + 7'd1,
            ASCII_ZERO + 7'd9, ASCII_ZERO + 7'd6, ASCII_ZERO + 7'd3, ASCII_P}},
        // noon, same date
        '{HOUR_MODE_12, DATE_ORDER_MDY, 16'h6000, 16'hFFFF, 1'b1,
          '{1'b0, ASCII_ZERO + 7'd1, ASCII_ZERO + 7'd5, ASCII_ZERO + 7'd3,
            ASCII_ZERO + 7'd1, ASCII_ZERO, ASCII_ZERO + 7'd7, ASCII_ZERO + 7'd1,
            ASCII_ZERO + 7'd2, ASCII_ZERO, ASCII_ZERO, ASCII_P}},
        '{HOUR_MODE_12, DATE_ORDER_MDY, 16'h6800, 16'h5825, 1'b0, NO_TEXT},
        '{HOUR_MODE_12, DATE_ORDER_MDY, 16'h5F60, 16'h5825, 1'b0, NO_TEXT},
        '{HOUR_MODE_12, DATE_ORDER_MDY, 16'hBF60, 16'h0021, 1'b0, NO_TEXT},
        '{HOUR_MODE_12, DATE_ORDER_MDY, 16'hC01F, 16'h0000, 1'b0, NO_TEXT},
        '{HOUR_MODE_12, DATE_ORDER_MDY, 16'h0800, 16'h2600, 1'b0, NO_TEXT},
        '{HOUR_MODE_12, DATE_ORDER_DMY, 16'h7FFF, 16'h00E9, 1'b0, NO_TEXT},
        // year fields 120 and 20 give the same year
        '{HOUR_MODE_12, DATE_ORDER_DMY, 16'h0000, 16'hF000, 1'b0, NO_TEXT},
        '{HOUR_MODE_12, DATE_ORDER_DMY, 16'h0000, 16'h2800, 1'b0, NO_TEXT},
        '{HOUR_MODE_12, DATE_ORDER_SPARE, 16'h4B20, 16'h0198, 1'b0, NO_TEXT},
        // twenty-four-hour, year first, hour zero blanked, no suffix
        '{HOUR_MODE_24, DATE_ORDER_YMD, 16'h0000, 16'hFFFF, 1'b1,
          '{1'b1, ASCII_ZERO, ASCII_ZERO + 7'd7, ASCII_ZERO + 7'd1,
            ASCII_ZERO + 7'd5, ASCII_ZERO + 7'd3, ASCII_ZERO + 7'd1, ASCII_SPACE,
            ASCII_ZERO, ASCII_ZERO, ASCII_ZERO, 7'd0}},
        '{HOUR_MODE_24, DATE_ORDER_YMD, 16'hFFFF, 16'h1234, 1'b0, NO_TEXT},
        '{HOUR_MODE_24, DATE_ORDER_YMD, 16'hBF60, 16'h1234, 1'b0, NO_TEXT},
        '{HOUR_MODE_24, DATE_ORDER_DMY, 16'h0000, 16'h5825, 1'b0, NO_TEXT},
        '{HOUR_MODE_24, DATE_ORDER_DMY, 16'h5000, 16'hFE1F, 1'b0, NO_TEXT},
        '{HOUR_MODE_24, DATE_ORDER_MDY, 16'hAAAA, 16'h5555, 1'b0, NO_TEXT},
        '{HOUR_MODE_24, DATE_ORDER_MDY, 16'h5555, 16'hAAAA, 1'b0, NO_TEXT}
    };

    // settings for the random runs: {hour mode, date order}
    localparam logic [2:0] RUN_SETTINGS [8] = '{
        {HOUR_MODE_12, DATE_ORDER_MDY}, {HOUR_MODE_24, DATE_ORDER_YMD},
        {HOUR_MODE_12, DATE_ORDER_DMY}, {HOUR_MODE_24, DATE_ORDER_SPARE},
        {HOUR_MODE_24, DATE_ORDER_MDY}, {HOUR_MODE_12, DATE_ORDER_YMD},
        {HOUR_MODE_24, DATE_ORDER_DMY}, {HOUR_MODE_12, DATE_ORDER_SPARE}
    };

    string field_names [12] = '{"date_changed", "date_char0", "date_char1",
        "date_char2", "date_char3", "date_char4", "date_char5", "time_char0",
        "time_char1", "time_char2", "time_char3", "time_char4"};

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [15:0] time_word = '0;
    logic [15:0] date_word = '0;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [1:0]  cfg_data = '0;

    logic        in_ready;
    logic        out_valid;
    logic        cfg_ready;
    logic        date_changed;
    logic [6:0]  date_char [6];
    logic [6:0]  time_char [5];

    // model state
    logic        hour_mode_q = HOUR_MODE_12;
    logic [1:0]  date_order_q = DATE_ORDER_MDY;
    t_date       last_date = '0;
    t_result     pending_text [$];

    int send_idle_pct = 14;
    int recv_idle_pct = 49;
    int mismatch_count = 0;
    int cycle_count = 0;

    always #1 i_clk = ~i_clk;

    packed_date_time_to_display_text dut (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_time_word    (time_word),
        .i_date_word    (date_word),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_date_changed (date_changed),
        .o_date_char0   (date_char[0]),
        .o_date_char1   (date_char[1]),
        .o_date_char2   (date_char[2]),
        .o_date_char3   (date_char[3]),
        .o_date_char4   (date_char[4]),
        .o_date_char5   (date_char[5]),
        .o_time_char0   (time_char[0]),
        .o_time_char1   (time_char[1]),
        .o_time_char2   (time_char[2]),
        .o_time_char3   (time_char[3]),
        .o_time_char4   (time_char[4]),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    // decimal digits as ascii
    function automatic logic [6:0] tens_ascii(input logic [6:0] v, input logic blank);
        logic [6:0] t;
        t = v / 7'd10;
        return (blank && t == 7'd0) ? ASCII_SPACE : ASCII_ZERO + t;
    endfunction

    function automatic logic [6:0] units_ascii(input logic [6:0] v);
        return ASCII_ZERO + v % 7'd10;
    endfunction

    // text for one word; updates the stored date
    function automatic t_result predict_text(input logic [15:0] tw, input logic [15:0] dw);
        t_date      cur;
        logic [4:0] hour;
        logic [4:0] shown;
        logic [6:0] f0, f1, f2;
        logic       blank0;
        t_result    r;
        hour      = tw[15:11];
        cur.day   = dw[4:0];
        cur.month = dw[8:5];
        cur.year  = 7'((8'(dw[15:9]) + YEAR_BASE) % YEAR_WRAP);
        r.date_changed = (cur != last_date);
        if (r.date_changed) begin
            last_date = cur;
        end
        // field order on screen
        case (date_order_q)
            DATE_ORDER_YMD: begin
                f0 = cur.year; f1 = 7'(cur.month); f2 = 7'(cur.day); blank0 = 1'b0;
            end
            DATE_ORDER_DMY: begin
                f0 = 7'(cur.day); f1 = 7'(cur.month); f2 = cur.year; blank0 = 1'b1;
            end
            default: begin
                f0 = 7'(cur.month); f1 = 7'(cur.day); f2 = cur.year; blank0 = 1'b1;
            end
        endcase
        // twelve-hour fold, midnight shows as twelve
        if (hour_mode_q == HOUR_MODE_24) begin
            shown = hour;
        end else if (hour == 5'd0) begin
            shown = HOUR_NOON;
        end else if (hour > HOUR_NOON) begin
            shown = hour - HOUR_NOON;
        end else begin
            shown = hour;
        end
        r.date_char0 = tens_ascii(f0, blank0);
        r.date_char1 = units_ascii(f0);
        r.date_char2 = tens_ascii(f1, 1'b0);
        r.date_char3 = units_ascii(f1);
        r.date_char4 = tens_ascii(f2, 1'b0);
        r.date_char5 = units_ascii(f2);
        r.time_char0 = tens_ascii(7'(shown), 1'b1);
        r.time_char1 = units_ascii(7'(shown));
        r.time_char2 = tens_ascii(7'(tw[10:5]), 1'b0);
        r.time_char3 = units_ascii(7'(tw[10:5]));
        if (hour_mode_q == HOUR_MODE_24) begin
            r.time_char4 = 7'd0;
        end else begin
            r.time_char4 = (hour < HOUR_NOON) ? ASCII_A : ASCII_P;
        end
        return r;
    endfunction

    // send one input word, called at a rising edge
    task automatic push_word(input logic [15:0] tw, input logic [15:0] dw,
                             input logic typed, input t_result given);
        t_result predicted;
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid  <= 1'b1;
        time_word <= tw;
        date_word <= dw;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        predicted = predict_text(tw, dw);
        pending_text.push_back(typed ? given : predicted);
    endtask

    // one register write; valid stays high for a following write
    task automatic write_reg(input logic [1:0] idx, input logic [1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        if (idx == CFG_IDX_HOUR_MODE) begin
            hour_mode_q = data[0];
        end else if (idx == CFG_IDX_DATE_ORDER) begin
            date_order_q = data;
        end
    endtask

    task automatic set_config(input logic hm, input logic [1:0] ord);
        write_reg(CFG_IDX_HOUR_MODE, {1'($urandom), hm});
        write_reg(CFG_IDX_DATE_ORDER, ord);
        cfg_valid <= 1'b0;
    endtask

    // hold the source until every result word is back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_text.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    // result checking and sink stalls
    always @(posedge i_clk) begin
        t_result    got;
        t_result    want;
        logic [6:0] got_f;
        logic [6:0] want_f;
        if (rst_n && out_valid && out_ready) begin
            got = {date_changed, date_char[0], date_char[1], date_char[2],
                   date_char[3], date_char[4], date_char[5], time_char[0],
                   time_char[1], time_char[2], time_char[3], time_char[4]};
            if (pending_text.size() == 0) begin
                $display("%0t: result word with none expected, actual %h", $time, got);
                mismatch_count++;
            end else begin
                want = pending_text.pop_front();
                for (int i = 0; i < 12; i++) begin
                    got_f  = 7'(got >> ((11 - i) * 7));
                    want_f = 7'(want >> ((11 - i) * 7));
                    if (got_f !== want_f) begin
                        $display("%0t: %s expected %h actual %h",
                                 $time, field_names[i], want_f, got_f);
                        mismatch_count++;
                    end
                end
            end
        end
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_packed_date_time_to_display_text: FAIL");
            $finish;
        end
    end

    initial begin
        t_row        row;
        logic [15:0] tw;
        logic [15:0] dw;
        logic [15:0] last_dw;
        logic [2:0]  run_cfg;
        int          pick;
        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // unused register index, must leave the settings alone
        write_reg(CFG_IDX_SPARE, 2'($urandom));

        // directed table
        for (int i = 0; i < NUM_ROWS; i++) begin
            row = DIRECTED[i];
            if (i == 0 || row.hm != hour_mode_q || row.ord != date_order_q) begin
                drain_results();
                set_config(row.hm, row.ord);
            end
            push_word(row.tw, row.dw, row.typed, row.res);
        end
        last_dw = DIRECTED[NUM_ROWS - 1].dw;

        // random runs under three stall patterns
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 49 : 0;
            recv_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 14 : 0;
            for (int run = 0; run < 4; run++) begin
                run_cfg = RUN_SETTINGS[(phase * 4 + run) % 8];
                drain_results();
                set_config(run_cfg[2], run_cfg[1:0]);
                for (int n = 0; n < RUN_WORDS; n++) begin
                    // mostly legal times, some raw words
                    if ($urandom_range(99) < 65) begin
                        tw = {5'($urandom_range(23)), 6'($urandom_range(59)), 5'($urandom)};
                    end else begin
                        tw = 16'($urandom);
                    end
                    // repeat the date often so both change flags show up
                    pick = $urandom_range(99);
                    if (pick < 40) begin
                        dw = last_dw;
                    end else if (pick < 50) begin
                        dw = last_dw;
                        if (dw[15:9] < 7'd28) begin
                            dw[15:9] = dw[15:9] + 7'd100;
                        end else if (dw[15:9] >= 7'd100) begin
                            dw[15:9] = dw[15:9] - 7'd100;
                        end
                    end else if (pick < 80) begin
                        dw = {7'($urandom_range(127)), 4'($urandom_range(1, 12)),
                              5'($urandom_range(1, 31))};
                    end else begin
                        dw = 16'($urandom);
                    end
                    last_dw = dw;
                    push_word(tw, dw, 1'b0, NO_TEXT);
                end
            end
        end

        drain_results();
        if (mismatch_count == 0) begin
            $display("tb_packed_date_time_to_display_text: PASS");
        end else begin
            $display("tb_packed_date_time_to_display_text: FAIL");
        end
        $finish;
    end

endmodule
